// ----- hdl/mrbm_pkg.sv -----
package mrbm_pkg;

	// Matrix limits.
	localparam int COLS_MAX = 64;
	localparam int ROWS_MAX = 64;

	// Derived widths.
	localparam int COL_W     = $clog2(COLS_MAX + 1);
	localparam int ADDR_W    = $clog2(COLS_MAX);
	localparam int HGT_W     = $clog2(ROWS_MAX + 1);
	localparam int STK_DEPTH = COLS_MAX + 1;
	localparam int STK_AW    = $clog2(STK_DEPTH);
	localparam int AREA_W    = 13;
	localparam int ROW_LEN_W = 7;

	localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST = ROW_LEN_W'(64);

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_FETCH,
		S_CMP,
		S_POP,
		S_AREA,
		S_FIN
	} state_t;

	// One entry of the monotonic stack: column index and its height.
	typedef struct packed {
		logic [COL_W-1:0] idx;
		logic [HGT_W-1:0] hgt;
	} stk_ent_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic upd;
		logic fetch;
		logic push;
		logic pop;
		logic area;
		logic fin_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic row_done;
		logic last;
		logic pop_ok;
		logic at_end;
		logic out_free;
	} status_t;

endpackage

// ----- hdl/max_rectangle_binary_matrix_top.sv -----
// Each input beat passes the idle and update states; a beat that ends a row adds a row scan
// made of the fetch, compare, pop and area steps of the stack sequencer.
// The result is loaded into the output register when the scan after the last cell ends;
// it waits only while the previous result is still stalled.
// Reset clears the controller, the counters, the best area and all column valid bits at
// once, so every column height reads as zero; row_length returns to 64.
module max_rectangle_binary_matrix_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mrbm_pkg::ROW_LEN_W-1:0] row_length,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cell_req,
	input  logic                           last_cell,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mrbm_pkg::AREA_W-1:0]    max_area
);

	mrbm_pkg::cmd_t    cmd;
	mrbm_pkg::status_t sts;

	// Sequencer.
	mrbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Heights, stack and area datapath.
	mrbm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.row_length (row_length),
		.cell_req   (cell_req),
		.last_cell  (last_cell),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.max_area   (max_area)
	);

endmodule

// ----- hdl/mrbm_ctrl.sv -----
module mrbm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  mrbm_pkg::status_t sts,
	output logic             in_stall,
	output mrbm_pkg::cmd_t   cmd
);

	mrbm_pkg::state_t state_q;
	mrbm_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrbm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Input beats are taken only between items.
	assign in_stall = (state_q != mrbm_pkg::S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			mrbm_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = mrbm_pkg::S_UPD;
				end
			end
			mrbm_pkg::S_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.row_done ? mrbm_pkg::S_FETCH : mrbm_pkg::S_IDLE;
			end
			mrbm_pkg::S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = mrbm_pkg::S_CMP;
			end
			mrbm_pkg::S_CMP: begin
				if (sts.pop_ok) begin
					cmd.pop = 1'b1;
					state_d = mrbm_pkg::S_POP;
				end else if (sts.at_end) begin
					state_d = mrbm_pkg::S_FIN;
				end else begin
					cmd.push = 1'b1;
					state_d  = mrbm_pkg::S_FETCH;
				end
			end
			mrbm_pkg::S_POP: begin
				state_d = mrbm_pkg::S_AREA;
			end
			mrbm_pkg::S_AREA: begin
				cmd.area = 1'b1;
				state_d  = mrbm_pkg::S_CMP;
			end
			mrbm_pkg::S_FIN: begin
				if (!sts.last) begin
					state_d = mrbm_pkg::S_IDLE;
				end else if (sts.out_free) begin
					cmd.fin_load = 1'b1;
					state_d      = mrbm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mrbm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/mrbm_dp.sv -----
module mrbm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mrbm_pkg::ROW_LEN_W-1:0]    row_length,
	input  logic                              cell_req,
	input  logic                              last_cell,
	input  logic                              out_stall,
	input  mrbm_pkg::cmd_t                    cmd,
	output mrbm_pkg::status_t                 sts,
	output logic                              out_valid,
	output logic [mrbm_pkg::AREA_W-1:0]       max_area
);

	localparam int COL_W  = mrbm_pkg::COL_W;
	localparam int ADDR_W = mrbm_pkg::ADDR_W;
	localparam int HGT_W  = mrbm_pkg::HGT_W;
	localparam int STK_AW = mrbm_pkg::STK_AW;
	localparam int AREA_W = mrbm_pkg::AREA_W;
	localparam int RL_W   = mrbm_pkg::ROW_LEN_W;

	// Column height memory with one valid bit per column.
	logic [HGT_W-1:0]    h_mem [mrbm_pkg::COLS_MAX];
	logic [mrbm_pkg::COLS_MAX-1:0] h_vld_q;
	logic [HGT_W-1:0]    h_rd_q;
	logic                h_rv_q;

	// Stack memory of column indices and heights.
	mrbm_pkg::stk_ent_t  stk_mem [mrbm_pkg::STK_DEPTH];
	mrbm_pkg::stk_ent_t  stk_rd_q;
	mrbm_pkg::stk_ent_t  top_q;
	mrbm_pkg::stk_ent_t  push_ent;

	logic [RL_W-1:0]     row_len_q;
	logic [RL_W-1:0]     eff_len;
	logic [COL_W-1:0]    count_q;
	logic [COL_W:0]      cnt_inc;
	logic [COL_W-1:0]    cols_q;
	logic [COL_W-1:0]    i_q;
	logic [STK_AW-1:0]   sd_q;
	logic                cell_q;
	logic                last_q;
	logic                i_lt;
	logic [HGT_W-1:0]    cur;
	logic [HGT_W-1:0]    h_old;
	logic [HGT_W-1:0]    h_new;
	logic [COL_W-1:0]    left;
	logic [COL_W-1:0]    span;
	logic [HGT_W+COL_W-1:0] prod;
	logic [AREA_W-1:0]   area_s1;
	logic                area_vld_s1;
	logic [AREA_W-1:0]   best_q;
	logic                out_vld_q;
	logic [AREA_W-1:0]   max_area_q;

	// Row length clamped to 1..COLS_MAX.
	always_comb begin
		if (row_len_q == '0) begin
			eff_len = RL_W'(1);
		end else if (row_len_q > RL_W'(mrbm_pkg::COLS_MAX)) begin
			eff_len = RL_W'(mrbm_pkg::COLS_MAX);
		end else begin
			eff_len = row_len_q;
		end
	end

	// Height update for the cell in hand, saturating at ROWS_MAX.
	always_comb begin
		h_old = h_rv_q ? h_rd_q : '0;
		if (!cell_q) begin
			h_new = '0;
		end else if (h_old < HGT_W'(mrbm_pkg::ROWS_MAX)) begin
			h_new = h_old + HGT_W'(1);
		end else begin
			h_new = HGT_W'(mrbm_pkg::ROWS_MAX);
		end
	end

	// Row scan terms: current height, pop test and rectangle width.
	always_comb begin
		cnt_inc   = {1'b0, count_q} + (COL_W + 1)'(1);
		i_lt      = (i_q < cols_q);
		cur       = (i_lt && h_rv_q) ? h_rd_q : '0;
		push_ent.idx = i_q;
		push_ent.hgt = cur;
		left      = (sd_q != '0) ? (stk_rd_q.idx + COL_W'(1)) : '0;
		span      = i_q - left;
		prod      = {{COL_W{1'b0}}, top_q.hgt} * {{HGT_W{1'b0}}, span};
	end

	// Status toward the controller.
	always_comb begin
		sts.row_done = (cnt_inc >= {1'b0, eff_len}) || last_q;
		sts.last     = last_q;
		sts.pop_ok   = (sd_q != '0) && (top_q.hgt >= cur);
		sts.at_end   = !i_lt;
		sts.out_free = !out_vld_q || !out_stall;
	end

	// Height memory port.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			h_rd_q <= h_mem[count_q[ADDR_W-1:0]];
		end else if (cmd.fetch) begin
			h_rd_q <= h_mem[i_q[ADDR_W-1:0]];
		end
		if (cmd.upd) begin
			h_mem[count_q[ADDR_W-1:0]] <= h_new;
		end
	end

	// Stack memory port.
	always_ff @(posedge clk) begin
		if (cmd.push && i_lt) begin
			stk_mem[sd_q] <= push_ent;
		end
		if (cmd.pop && (sd_q > STK_AW'(1))) begin
			stk_rd_q <= stk_mem[sd_q - STK_AW'(2)];
		end
	end

	// Control and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q   <= mrbm_pkg::ROW_LEN_RST;
			h_vld_q     <= '0;
			h_rv_q      <= 1'b0;
			count_q     <= '0;
			cols_q      <= '0;
			i_q         <= '0;
			sd_q        <= '0;
			top_q       <= '0;
			cell_q      <= 1'b0;
			last_q      <= 1'b0;
			area_s1     <= '0;
			area_vld_s1 <= 1'b0;
			best_q      <= '0;
			out_vld_q   <= 1'b0;
			max_area_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				row_len_q <= row_length;
			end

			// Take the input beat and look up its column.
			if (cmd.accept) begin
				cell_q <= cell_req;
				last_q <= last_cell;
				h_rv_q <= h_vld_q[count_q[ADDR_W-1:0]];
			end else if (cmd.fetch) begin
				h_rv_q <= h_vld_q[i_q[ADDR_W-1:0]];
			end

			// Write the new height and start a row scan at row end.
			if (cmd.upd) begin
				h_vld_q[count_q[ADDR_W-1:0]] <= 1'b1;
				if (sts.row_done) begin
					cols_q  <= cnt_inc[COL_W-1:0];
					count_q <= '0;
					i_q     <= '0;
					sd_q    <= '0;
				end else begin
					count_q <= cnt_inc[COL_W-1:0];
				end
			end

			// Push the current column and move on.
			if (cmd.push) begin
				if (i_lt) begin
					top_q <= push_ent;
					sd_q  <= sd_q + STK_AW'(1);
				end
				i_q <= i_q + COL_W'(1);
			end

			if (cmd.pop) begin
				sd_q <= sd_q - STK_AW'(1);
			end

			// Area of the popped bar; the next stack entry becomes the top.
			area_vld_s1 <= cmd.area;
			if (cmd.area) begin
				area_s1 <= prod[AREA_W-1:0];
				if (sd_q != '0) begin
					top_q <= stk_rd_q;
				end
			end

			// Best area so far, cleared once it is reported.
			if (cmd.fin_load) begin
				best_q <= '0;
			end else if (area_vld_s1 && (area_s1 > best_q)) begin
				best_q <= area_s1;
			end

			// Output register and clearing after a report.
			if (cmd.fin_load) begin
				out_vld_q  <= 1'b1;
				max_area_q <= best_q;
				h_vld_q    <= '0;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign max_area  = max_area_q;

endmodule
